FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/dtti_pkg.sv
// ----------------------------------------------------------------------------
// dtti_pkg
// Beat types and character constants of the decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtti_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overflowed;
    } result_t;

    // one parsed string handed from the scanner to the scaler
    typedef struct packed {
        logic [31:0] mantissa;
        logic        negate;
        logic        exp_negative;
        logic [6:0]  exp_count;
        logic        saturated;
    } job_t;

    localparam logic [31:0] MANT_LIMIT    = 32'd214748363;
    localparam logic [31:0] SAT_VALUE     = 32'h7FFF_FFFF;
    localparam logic [6:0]  EXP_MAX       = 7'd99;
    localparam logic [6:0]  DIV_EXP_LIMIT = 7'd10;
    localparam logic [7:0]  CHAR_ZERO     = 8'd48;
    localparam logic [7:0]  CHAR_NINE     = 8'd57;
    localparam logic [7:0]  CHAR_E        = 8'h45;
    localparam logic [7:0]  CHAR_PLUS     = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS    = 8'h2D;
    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT   = 35;

endpackage

FILE: rtl/core/decimal_text_to_integer_core.sv
// Path: the last character's beat queues a job; the scaler applies N exponent steps, where
//   N is the exponent magnitude (0 with no exponent, on overflow, or for a negative one of
//   10+), then queues the result. Throughput: one beat per cycle while full is low; the
//   scaler takes one string at a time, and the job queue lets the scanner run ahead of it.
// Reset: rst_n is asynchronous and active low; it clears the parser, both queues and
//   exponent_enable. No clearing pass; the block takes beats right after reset.
// ----------------------------------------------------------------------------
// decimal_text_to_integer_core
// ASCII decimal text to 32-bit integer converter with optional E exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_text_to_integer_core #(
    parameter int JOB_DEPTH    = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    // character beats
    input  logic              push,
    input  dtti_pkg::item_t   item,
    output logic              full,
    // result beats
    input  logic              pop,
    output logic              empty,
    output dtti_pkg::result_t result,
    // configuration
    input  logic              cfg_write_en,
    input  logic              cfg_write_data
);

    logic              exp_enable_reg;

    logic              job_push;
    dtti_pkg::job_t    job_in;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;
    dtti_pkg::job_t    job_head;

    logic              res_push;
    dtti_pkg::result_t res_in;
    logic              res_full;

    // Exponent enable; the scanner samples it when an E arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            exp_enable_reg <= cfg_write_data;
        end
    end

    // Front: scans one character per cycle unless full, and emits a job on the last one.
    dtti_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .exponent_enable (exp_enable_reg),
        .push            (push),
        .item            (item),
        .full            (full),
        .job_push        (job_push),
        .job             (job_in),
        .job_full        (job_full)
    );

    // Decouples the scanner from the iterative scaler.
    dtti_queue #(
        .T     (dtti_pkg::job_t),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .data_in  (job_in),
        .pop      (job_pop),
        .full     (job_full),
        .empty    (job_empty),
        .data_out (job_head)
    );

    // Back: applies the exponent a step per cycle, then the sign.
    dtti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue: the scaler keeps going while a result waits for pop.
    dtti_queue #(
        .T     (dtti_pkg::result_t),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_in),
        .pop      (pop),
        .full     (res_full),
        .empty    (empty),
        .data_out (result)
    );

endmodule

FILE: rtl/core/dtti_queue.sv
// ----------------------------------------------------------------------------
// dtti_queue
// Small register queue used between scanner, scaler and result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtti_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     data_in,
    input  logic pop,
    output logic full,
    output logic empty,
    output T     data_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

FILE: rtl/core/dtti_front.sv
// ----------------------------------------------------------------------------
// dtti_front
// Character scanner: signs, mantissa digits and exponent, one beat a cycle unless full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtti_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exponent_enable,
    input  logic            push,
    input  dtti_pkg::item_t item,
    output logic            full,
    output logic            job_push,
    output dtti_pkg::job_t  job,
    input  logic            job_full
);

    typedef enum logic [4:0] {
        PH_SIGN    = 5'b00001,
        PH_MANT    = 5'b00010,
        PH_EXPSIGN = 5'b00100,
        PH_EXPDIG  = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        negate_reg, negate_next;
    logic [31:0] acc_reg, acc_next;
    logic        exp_neg_reg, exp_neg_next;
    logic [6:0]  exp_cnt_reg, exp_cnt_next;
    logic        sat_reg, sat_next;

    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [31:0] acc_times10;
    logic [9:0]  exp_wide;
    logic [6:0]  exp_sat;
    logic        do_mant;
    logic        do_exp;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign job_push = accept && item.last;

    assign is_digit = (item.character >= dtti_pkg::CHAR_ZERO) &&
                      (item.character <= dtti_pkg::CHAR_NINE);
    assign digit    = item.character[3:0];
    assign acc_times10 = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + {28'd0, digit};
    assign exp_wide = {exp_cnt_reg, 3'b000} + {2'b00, exp_cnt_reg, 1'b0} + {6'd0, digit};
    assign exp_sat  = (exp_wide > {3'b000, dtti_pkg::EXP_MAX}) ? dtti_pkg::EXP_MAX
                                                               : exp_wide[6:0];

    always_comb
    begin
        phase_next   = phase_reg;
        negate_next  = negate_reg;
        acc_next     = acc_reg;
        exp_neg_next = exp_neg_reg;
        exp_cnt_next = exp_cnt_reg;
        sat_next     = sat_reg;
        do_mant      = 1'b0;
        do_exp       = 1'b0;

        case (phase_reg)
            PH_SIGN:
            begin
                if (item.character == dtti_pkg::CHAR_MINUS)
                begin
                    negate_next = !negate_reg;
                end
                else if (item.character != dtti_pkg::CHAR_PLUS)
                begin
                    do_mant = 1'b1;
                end
            end
            PH_MANT:
            begin
                do_mant = 1'b1;
            end
            PH_EXPSIGN:
            begin
                phase_next = PH_EXPDIG;
                if (item.character == dtti_pkg::CHAR_MINUS)
                begin
                    exp_neg_next = 1'b1;
                end
                else if (is_digit)
                begin
                    do_exp = 1'b1;
                end
                else if (item.character != dtti_pkg::CHAR_PLUS)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_EXPDIG:
            begin
                if (is_digit)
                begin
                    do_exp = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (do_mant)
        begin
            if (is_digit)
            begin
                if (acc_reg > dtti_pkg::MANT_LIMIT)
                begin
                    sat_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next   = acc_times10;
                    phase_next = PH_MANT;
                end
            end
            else if ((item.character == dtti_pkg::CHAR_E) && exponent_enable && !item.last)
            begin
                phase_next = PH_EXPSIGN;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (do_exp)
        begin
            exp_cnt_next = exp_sat;
        end
    end

    assign job.mantissa     = acc_next;
    assign job.negate       = negate_next;
    assign job.exp_negative = exp_neg_next;
    assign job.exp_count    = exp_cnt_next;
    assign job.saturated    = sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIGN;
            negate_reg  <= 1'b0;
            acc_reg     <= '0;
            exp_neg_reg <= 1'b0;
            exp_cnt_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last)
            begin
                phase_reg   <= PH_SIGN;
                negate_reg  <= 1'b0;
                acc_reg     <= '0;
                exp_neg_reg <= 1'b0;
                exp_cnt_reg <= '0;
                sat_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                negate_reg  <= negate_next;
                acc_reg     <= acc_next;
                exp_neg_reg <= exp_neg_next;
                exp_cnt_reg <= exp_cnt_next;
                sat_reg     <= sat_next;
            end
        end
    end

endmodule

FILE: rtl/core/dtti_back.sv
// ----------------------------------------------------------------------------
// dtti_back
// Exponent scaler: one multiply or divide by ten per cycle, then the sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtti_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_empty,
    input  dtti_pkg::job_t    job,
    output logic              job_pop,
    input  logic              res_full,
    output logic              res_push,
    output dtti_pkg::result_t res
);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [31:0] val_reg, val_next;
    logic [6:0]  rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic        div_reg, div_next;
    logic        ovf_reg, ovf_next;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] times10;
    logic        to_zero;

    // divide by ten through the reciprocal
    assign prod    = {32'd0, val_reg} * {32'd0, dtti_pkg::RECIP_TEN};
    assign quot    = {3'b000, prod[63:dtti_pkg::RECIP_SHIFT]};
    assign times10 = {val_reg[28:0], 3'b000} + {val_reg[30:0], 1'b0};
    assign to_zero = job.exp_negative && (job.exp_count >= dtti_pkg::DIV_EXP_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        ovf_next   = ovf_reg;
        job_pop    = 1'b0;
        res_push   = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_RUN;
                    div_next   = job.exp_negative;
                    ovf_next   = job.saturated;
                    if (job.saturated)
                    begin
                        val_next = dtti_pkg::SAT_VALUE;
                        rem_next = '0;
                        neg_next = 1'b0;
                    end
                    else if (to_zero)
                    begin
                        val_next = '0;
                        rem_next = '0;
                        neg_next = job.negate;
                    end
                    else
                    begin
                        val_next = job.mantissa;
                        rem_next = job.exp_count;
                        neg_next = job.negate;
                    end
                end
            end
            BK_RUN:
            begin
                if (rem_reg != '0)
                begin
                    val_next = div_reg ? quot : times10;
                    rem_next = rem_reg - 1'b1;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res.value      = $signed(neg_reg ? (32'd0 - val_reg) : val_reg);
    assign res.overflowed = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        neg_reg <= neg_next;
        div_reg <= div_next;
        ovf_reg <= ovf_next;
    end

endmodule

FILE: rtl/core/dtti_checker.sv
// ----------------------------------------------------------------------------
// dtti_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtti_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pop,
    input logic              empty,
    input dtti_pkg::result_t result
);

    logic res_stall;
    logic sat_shown;

    assign res_stall = !empty && !pop;
    assign sat_shown = !empty && result.overflowed;

    // a waiting result beat holds until popped
    `ASSERT_NEXT(a_result_holds, clk, rst_n, res_stall, !empty && $stable(result))
    // the overflow flag always comes with the saturated value
    `ASSERT_IMPLIES(a_overflow_value, clk, rst_n, sat_shown, result.value == 32'sh7FFF_FFFF)
    // results leave only by pop
    `ASSERT_IMPLIES(a_empty_by_pop, clk, rst_n, $rose(empty), $past(pop))

endmodule

bind decimal_text_to_integer_core dtti_checker u_dtti_checker (.*);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_text_to_integer_core. Strings of character
// beats are fed through the push/full port; a cycle-free parser model in the
// bench predicts every converted value, and each popped result is compared
// field by field. Directed strings cover signs, stop characters, the E
// exponent rules and saturation; random strings then run in three phases
// with exponent_enable at 1, 0 and 1, with random idle on both sides and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // drain wait for the worst case, a large positive exponent, plus margin
    localparam int SCALER_DRAIN     = 120;
    localparam int MAX_REPORTS      = 10;
    localparam int HOLD_CYCLES      = 400;
    localparam int HOLD_AFTER_BEATS = 300;

    typedef enum logic [2:0] {
        PARSE_SIGN,
        PARSE_MANTISSA,
        PARSE_EXP_SIGN,
        PARSE_EXP_DIGITS,
        PARSE_STOPPED
    } parse_phase_t;

    // every block input has a known value from time 0
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              push           = 1'b0;
    dtti_pkg::item_t   item           = '0;
    logic              full;
    logic              pop            = 1'b0;
    logic              empty;
    dtti_pkg::result_t result;
    logic              cfg_write_en   = 1'b0;
    logic              cfg_write_data = 1'b0;

    dtti_pkg::item_t   char_beats[$];             // beats not yet accepted by the block
    dtti_pkg::result_t predicted_conversions[$];  // converted values still owed
    logic [7:0]        text_buf[$];               // string under construction

    // shadow of the parser and the register
    parse_phase_t scan_phase        = PARSE_SIGN;
    logic         sign_flip         = 1'b0;
    logic [31:0]  mantissa          = '0;
    logic         exp_neg           = 1'b0;
    logic [6:0]   exp_digits        = '0;
    logic         mant_overflow     = 1'b0;
    logic         exp_enable_shadow = 1'b0;

    int                chars_queued   = 0;
    int                chars_accepted = 0;
    int                results_seen   = 0;
    int                mismatches     = 0;
    int                in_wait        = 0;
    int                out_wait       = 0;
    int                hold_left      = 0;
    bit                hold_used      = 1'b0;
    bit                in_fired       = 1'b0;
    dtti_pkg::result_t owed;

    decimal_text_to_integer_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .item           (item),
        .full           (full),
        .pop            (pop),
        .empty          (empty),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return c >= dtti_pkg::CHAR_ZERO && c <= dtti_pkg::CHAR_NINE;
    endfunction

    task automatic exponent_digit(input logic [7:0] c);
        int e;
        e = int'(exp_digits) * 10 + int'(c - dtti_pkg::CHAR_ZERO);
        exp_digits = (e > int'(dtti_pkg::EXP_MAX)) ? dtti_pkg::EXP_MAX : 7'(e);
    endtask

    task automatic mantissa_character(input logic [7:0] c, input logic last);
        if (is_digit(c))
        begin
            // a digit on top of a too-large accumulator pins the result
            if (mantissa > dtti_pkg::MANT_LIMIT)
            begin
                mant_overflow = 1'b1;
                scan_phase    = PARSE_STOPPED;
            end
            else
            begin
                mantissa = mantissa * 32'd10 + {24'd0, c - dtti_pkg::CHAR_ZERO};
            end
        end
        // E opens an exponent only when enabled and not the final character
        else if (c == dtti_pkg::CHAR_E && exp_enable_shadow && !last)
        begin
            scan_phase = PARSE_EXP_SIGN;
        end
        else
        begin
            scan_phase = PARSE_STOPPED;
        end
    endtask

    task automatic parse_character(input dtti_pkg::item_t beat);
        logic [7:0]        c;
        logic [31:0]       v;
        logic [31:0]       p;
        dtti_pkg::result_t conv;
        c = beat.character;
        case (scan_phase)
            PARSE_SIGN:
            begin
                if (c == dtti_pkg::CHAR_MINUS)
                begin
                    sign_flip = !sign_flip;
                end
                else if (c != dtti_pkg::CHAR_PLUS)
                begin
                    scan_phase = PARSE_MANTISSA;
                    mantissa_character(c, beat.last);
                end
            end
            PARSE_MANTISSA:
            begin
                mantissa_character(c, beat.last);
            end
            PARSE_EXP_SIGN:
            begin
                if (c == dtti_pkg::CHAR_MINUS)
                begin
                    exp_neg    = 1'b1;
                    scan_phase = PARSE_EXP_DIGITS;
                end
                else if (c == dtti_pkg::CHAR_PLUS)
                begin
                    scan_phase = PARSE_EXP_DIGITS;
                end
                else if (is_digit(c))
                begin
                    scan_phase = PARSE_EXP_DIGITS;
                    exponent_digit(c);
                end
                else
                begin
                    scan_phase = PARSE_STOPPED;
                end
            end
            PARSE_EXP_DIGITS:
            begin
                if (is_digit(c))
                    exponent_digit(c);
                else
                    scan_phase = PARSE_STOPPED;
            end
            default:
            begin
            end
        endcase

        if (beat.last)
        begin
            v = mantissa;
            p = 32'd1;
            if (mant_overflow)
            begin
                v = dtti_pkg::SAT_VALUE;
            end
            else
            begin
                if (exp_digits != 0)
                begin
                    if (exp_neg && exp_digits >= dtti_pkg::DIV_EXP_LIMIT)
                    begin
                        // divisor beyond 10^9: nothing survives truncation
                        v = '0;
                    end
                    else
                    begin
                        for (int k = 0; k < int'(exp_digits); k++)
                            p = p * 32'd10;
                        v = exp_neg ? v / p : v * p;
                    end
                end
                if (sign_flip)
                    v = 32'd0 - v;
            end
            conv.value      = v;
            conv.overflowed = mant_overflow;
            predicted_conversions.push_back(conv);
            // parser restarts, register keeps its value
            scan_phase    = PARSE_SIGN;
            sign_flip     = 1'b0;
            mantissa      = '0;
            exp_neg       = 1'b0;
            exp_digits    = '0;
            mant_overflow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // idle count per beat; a slice of every stretch runs with no idle at all
    function automatic int draw_idle(input int beat_count, input int stretch);
        if (beat_count % stretch < stretch / 8)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // turn text_buf into beats, last marked on the final character
    task automatic commit_text();
        dtti_pkg::item_t beat;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            beat.character = text_buf[i];
            beat.last      = (i == text_buf.size() - 1);
            char_beats.push_back(beat);
        end
        chars_queued += text_buf.size();
        text_buf.delete();
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        commit_text();
    endtask

    // strings: mostly well formed with random content, some noise,
    // some with one character corrupted
    task automatic fill_random(input int count);
        int    target;
        int    form;
        int    n;
        int    k;
        string near_limit;
        target     = chars_queued + count;
        near_limit = "21474836";
        while (chars_queued < target)
        begin
            form = $urandom_range(0, 99);
            if (form < 15)
            begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++)
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                for (k = 0; k < n; k++)
                    text_buf.push_back($urandom_range(0, 1) ? dtti_pkg::CHAR_MINUS
                                                            : dtti_pkg::CHAR_PLUS);
                if ($urandom_range(0, 7) == 0)
                begin
                    // right around the overflow threshold
                    for (k = 0; k < near_limit.len(); k++)
                        text_buf.push_back(near_limit[k]);
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 12)
                                                    : $urandom_range(0, 9);
                end
                for (k = 0; k < n; k++)
                    text_buf.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1) == 1)
                begin
                    text_buf.push_back(dtti_pkg::CHAR_E);
                    k = $urandom_range(0, 2);
                    if (k == 1)
                        text_buf.push_back(dtti_pkg::CHAR_PLUS);
                    else if (k == 2)
                        text_buf.push_back(dtti_pkg::CHAR_MINUS);
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1;
                    for (k = 0; k < n; k++)
                        text_buf.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 4) == 0)
                    text_buf.push_back(8'($urandom_range(0, 255)));
                if (text_buf.size() == 0)
                    text_buf.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                if (form < 30)
                    text_buf[$urandom_range(0, text_buf.size() - 1)] =
                        8'($urandom_range(0, 255));
            end
            commit_text();
        end
    endtask

    // all beats taken, all results back, then let the scaler go quiet
    task automatic wait_drained();
        while (char_beats.size() != 0 || push || predicted_conversions.size() != 0)
            @(negedge clk);
        repeat (SCALER_DRAIN) @(negedge clk);
    endtask

    task automatic write_exp_enable(input logic v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: both handshakes and the config write
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                exp_enable_shadow = cfg_write_data;

            // character beat taken: run it through the model
            in_fired = push && !full;
            if (in_fired)
            begin
                parse_character(item);
                char_beats.delete(0);
                chars_accepted++;
                in_wait = (hold_left > 0) ? 0 : draw_idle(chars_accepted, 400);
            end

            // result beat taken: compare with the oldest prediction
            if (pop && !empty)
            begin
                results_seen++;
                out_wait = draw_idle(results_seen, 60);
                if (predicted_conversions.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d: none expected, got %0d ovf %0b",
                                            results_seen, result.value, result.overflowed));
                end
                else
                begin
                    owed = predicted_conversions.pop_front();
                    if (result.value !== owed.value)
                        flag_mismatch($sformatf("result %0d: value expected %0d got %0d",
                                                results_seen, owed.value, result.value));
                    if (result.overflowed !== owed.overflowed)
                        flag_mismatch($sformatf("result %0d: overflowed expected %0b got %0b",
                                                results_seen, owed.overflowed,
                                                result.overflowed));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers beats from char_beats, inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // an offered beat stays put until it is taken
            if (!push || in_fired)
            begin
                if (in_wait > 0)
                begin
                    push <= 1'b0;
                    in_wait--;
                end
                else if (char_beats.size() > 0)
                begin
                    push <= 1'b1;
                    item <= char_beats[0];
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random pop idle, forced low during the long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                pop <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                pop <= 1'b0;
                out_wait--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // long hold-off once enough beats went in; the sender keeps pushing
    // with no idle meanwhile, so both internal queues fill and full rises
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && chars_accepted >= HOLD_AFTER_BEATS)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // exponent disabled (reset value): sign toggling, E as a stop
        // character, a lone top-range byte
        send_literal("-+-7");
        send_literal("1E2");
        text_buf.push_back(8'hFF);
        commit_text();
        wait_drained();

        // exponent enabled: E as final character, exponent without digits,
        // negative exponent, saturated exponent count, wrap with sign
        write_exp_enable(1'b1);
        send_literal("9E");
        send_literal("5E-");
        send_literal("8E-1");
        send_literal("2E123");
        send_literal("-4E9");
        fill_random(650);
        wait_drained();

        write_exp_enable(1'b0);
        fill_random(500);
        wait_drained();

        write_exp_enable(1'b1);
        fill_random(600);
        wait_drained();

        if (mismatches == 0 && predicted_conversions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // several times the slowest correct run
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
